### hdl/intdiv_pkg.sv
// Shared width constant and pipeline stage record of the integer divider.
`default_nettype none
package intdiv_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int STEPS      = DATA_WIDTH;

    typedef enum logic
    {
        ACT_UNSIGNED = 1'b0,
        ACT_SIGNED   = 1'b1
    } action_t;

    // One division in flight: partial remainder, dividend/quotient shift word,
    // divisor magnitude and the flags that steer the last stage.
    typedef struct packed
    {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] den;
        logic                  neg;
        logic                  dbz;
    } stage_t;

endpackage
`default_nettype wire

### hdl/intdiv_step.sv
// One restoring-division stage: one quotient bit per item, registered.
`default_nettype none
module intdiv_step
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire intdiv_pkg::stage_t in_data,
    output logic                   out_valid,
    output intdiv_pkg::stage_t     out_data
);
    import intdiv_pkg::*;

    logic                  valid_reg;
    stage_t                data_reg;
    stage_t                data_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    always_comb
    begin
        trial     = {in_data.rem, in_data.nq[DATA_WIDTH-1]};
        diff      = trial - {1'b0, in_data.den};
        fits      = ~diff[DATA_WIDTH];
        data_next = in_data;
        if (in_data.dbz)
        begin
            // rotate the raw dividend so it comes back whole after all stages
            data_next.nq = {in_data.nq[DATA_WIDTH-2:0], in_data.nq[DATA_WIDTH-1]};
        end
        else
        begin
            data_next.rem = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            data_next.nq  = {in_data.nq[DATA_WIDTH-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### hdl/integer_divider_64bit.sv
// Top level of the pipelined 64-bit unsigned/signed integer divider.
// Pipeline: operand stage, 64 one-bit restoring stages, sign-fix stage; done rises
// together with the registered quotient and divide_by_zero.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
// The receiver cannot stall: each result shows for exactly one cycle with done.
`default_nettype none
module integer_divider_64bit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             action,
    input  wire logic [intdiv_pkg::DATA_WIDTH-1:0] dividend,
    input  wire logic [intdiv_pkg::DATA_WIDTH-1:0] divisor,
    output logic                                  done,
    output logic [intdiv_pkg::DATA_WIDTH-1:0]     quotient,
    output logic                                  divide_by_zero
);
    import intdiv_pkg::*;

    // Operand stage: take magnitudes, decide the sign of the quotient and
    // spot a zero divisor. The step chain sees only unsigned work.
    logic                  in_valid_reg;
    stage_t                in_data_reg;
    stage_t                in_data_next;
    logic                  n_neg;
    logic                  d_neg;
    logic                  is_signed;

    always_comb
    begin
        is_signed = (action == ACT_SIGNED);
        n_neg     = is_signed & dividend[DATA_WIDTH-1];
        d_neg     = is_signed & divisor[DATA_WIDTH-1];
        in_data_next.rem = '0;
        in_data_next.dbz = (divisor == '0);
        if (in_data_next.dbz)
        begin
            // pass the raw dividend through untouched
            in_data_next.nq  = dividend;
            in_data_next.den = '0;
            in_data_next.neg = 1'b0;
        end
        else
        begin
            in_data_next.nq  = n_neg ? (-dividend) : dividend;
            in_data_next.den = d_neg ? (-divisor) : divisor;
            in_data_next.neg = n_neg ^ d_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    // Step chain: one quotient bit per stage, most significant bit first.
    logic   chain_valid [0:STEPS];
    stage_t chain_data  [0:STEPS];

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        intdiv_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Output stage: negate when exactly one operand was negative. The most
    // negative value over minus one wraps back to itself here.
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] quotient_reg;
    logic [DATA_WIDTH-1:0] quotient_next;
    logic                  dbz_reg;

    always_comb
    begin
        quotient_next = chain_data[STEPS].neg ? (-chain_data[STEPS].nq)
                                              : chain_data[STEPS].nq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
        dbz_reg      <= chain_data[STEPS].dbz;
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = dbz_reg;

endmodule
`default_nettype wire

### sim/tb_integer_divider_64bit.sv
// Self-checking testbench for the pipelined 64-bit unsigned/signed integer divider.
`timescale 1ns / 1ps
module tb_integer_divider_64bit;

    import intdiv_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int PIPE_LATENCY = 66;
    localparam int N_RANDOM     = 1600;
    // The last items go out back to back, with no idle cycles in between.
    localparam int CALM_TAIL    = 300;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    // One division item as the block takes it.
    typedef struct packed
    {
        action_t               act;
        logic [DATA_WIDTH-1:0] n;
        logic [DATA_WIDTH-1:0] d;
    } div_req_t;

    // One result as the block returns it.
    typedef struct packed
    {
        logic [DATA_WIDTH-1:0] q;
        logic                  dbz;
    } quotient_rec_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  start          = 1'b0;
    logic                  action         = 1'b0;
    logic [DATA_WIDTH-1:0] dividend       = '0;
    logic [DATA_WIDTH-1:0] divisor        = '0;
    logic                  busy;
    logic                  done;
    logic [DATA_WIDTH-1:0] quotient;
    logic                  divide_by_zero;

    div_req_t      pending_items[$];
    quotient_rec_t expected_quotients[$];
    div_req_t      next_req;
    quotient_rec_t got_rec;
    quotient_rec_t want_rec;

    logic taken     = 1'b0;
    int   idle_left = 0;
    int   n_queued  = 0;
    int   n_taken   = 0;
    int   n_errors  = 0;

    integer_divider_64bit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Truncating division of magnitudes; flip the sign when exactly one
    // operand is negative. A zero divisor passes the dividend through.
    function automatic quotient_rec_t predict_quotient(div_req_t req);
        quotient_rec_t         r;
        logic [DATA_WIDTH-1:0] mag_n;
        logic [DATA_WIDTH-1:0] mag_d;
        logic [DATA_WIDTH-1:0] q;
        r.dbz = 1'b0;
        if (req.d == '0)
        begin
            r.q   = req.n;
            r.dbz = 1'b1;
        end
        else if (req.act == ACT_SIGNED)
        begin
            // The most negative value has magnitude 2^63, which fits unsigned.
            mag_n = req.n[DATA_WIDTH-1] ? -req.n : req.n;
            mag_d = req.d[DATA_WIDTH-1] ? -req.d : req.d;
            q     = mag_n / mag_d;
            // Most negative over minus one wraps back to itself here.
            r.q   = (req.n[DATA_WIDTH-1] ^ req.d[DATA_WIDTH-1]) ? -q : q;
        end
        else
        begin
            r.q = req.n / req.d;
        end
        return r;
    endfunction

    // Operand mix: full-width noise, values of every size, small and special
    // values, powers of two and negatives of every size.
    function automatic logic [DATA_WIDTH-1:0] random_operand();
        logic [DATA_WIDTH-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:    v = v >> $urandom_range(1, DATA_WIDTH - 1);
            5:       v = $urandom_range(0, 15);
            6:
            begin
                v = $urandom_range(1, 16);
                v = -v;
            end
            7:
            begin
                v = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1) == 1)
                    v = v - 1'b1;
            end
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = ALL_ONES;
                    3:       v = MOST_NEG;
                    4:       v = MOST_POS;
                    default: v = 2;
                endcase
            end
            default: v = -(v >> $urandom_range(1, DATA_WIDTH - 1));
        endcase
        return v;
    endfunction

    function automatic div_req_t random_request();
        div_req_t req;
        req.act = ($urandom_range(0, 1) == 1) ? ACT_SIGNED : ACT_UNSIGNED;
        req.n   = random_operand();
        req.d   = random_operand();
        // Dividend close to a multiple of the divisor: exact and near-exact quotients.
        if ($urandom_range(0, 7) == 0)
            req.n = req.d * $urandom_range(0, 1000) + $urandom_range(0, 3);
        return req;
    endfunction

    task automatic queue_item(action_t act, logic [DATA_WIDTH-1:0] n,
                              logic [DATA_WIDTH-1:0] d);
        pending_items.push_back('{act: act, n: n, d: d});
    endtask

    // Driver: change inputs on the falling edge. Hold an item until the block
    // takes it, then either idle for a burst or present the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !taken)
            begin
                // hold the current item
            end
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                if (pending_items.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                begin
                    // start an idle burst, its length drawn at random
                    start     <= 1'b0;
                    idle_left <= $urandom_range(0, 7);
                end
                else
                begin
                    next_req  = pending_items.pop_front();
                    start    <= 1'b1;
                    action   <= next_req.act;
                    dividend <= next_req.n;
                    divisor  <= next_req.d;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample on the rising edge. Predict each item the block takes;
    // compare each strobed result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            taken <= start && !busy;
            if (start && !busy)
            begin
                expected_quotients.push_back(predict_quotient(
                    '{act: action_t'(action), n: dividend, d: divisor}));
                n_taken = n_taken + 1;
            end
            if (done)
            begin
                got_rec = '{q: quotient, dbz: divide_by_zero};
                if (expected_quotients.size() == 0)
                begin
                    $error("unexpected result: quotient %h divide_by_zero %b",
                           got_rec.q, got_rec.dbz);
                    n_errors = n_errors + 1;
                end
                else
                begin
                    want_rec = expected_quotients.pop_front();
                    if (got_rec.q !== want_rec.q)
                    begin
                        $error("quotient: expected %h, actual %h", want_rec.q, got_rec.q);
                        n_errors = n_errors + 1;
                    end
                    if (got_rec.dbz !== want_rec.dbz)
                    begin
                        $error("divide_by_zero: expected %b, actual %b",
                               want_rec.dbz, got_rec.dbz);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        // Directed items: field extremes, both modes, and each special case.
        queue_item(ACT_UNSIGNED, ALL_ONES, ALL_ONES);
        queue_item(ACT_UNSIGNED, ALL_ONES, 1);
        queue_item(ACT_UNSIGNED, ALL_ONES, 2);
        queue_item(ACT_UNSIGNED, '0, 1);
        queue_item(ACT_UNSIGNED, 5, 7);                    // divisor above dividend
        queue_item(ACT_UNSIGNED, MOST_NEG, ALL_ONES);      // plain binary, not signed
        queue_item(ACT_UNSIGNED, ALL_ONES, '0);            // zero divisor
        queue_item(ACT_UNSIGNED, '0, '0);
        queue_item(ACT_SIGNED, MOST_NEG, ALL_ONES);        // most negative over minus one
        queue_item(ACT_SIGNED, MOST_NEG, 1);
        queue_item(ACT_SIGNED, MOST_NEG, MOST_NEG);
        queue_item(ACT_SIGNED, MOST_NEG, 2);
        queue_item(ACT_SIGNED, MOST_POS, MOST_NEG);        // divisor magnitude larger
        queue_item(ACT_SIGNED, MOST_POS, ALL_ONES);
        queue_item(ACT_SIGNED, -64'sd7, 2);                // rounds toward zero
        queue_item(ACT_SIGNED, 7, -64'sd2);
        queue_item(ACT_SIGNED, -64'sd7, -64'sd2);
        queue_item(ACT_SIGNED, 3, -64'sd5);
        queue_item(ACT_SIGNED, 1, ALL_ONES);
        queue_item(ACT_SIGNED, -64'sd9, '0);               // zero divisor, negative dividend
        queue_item(ACT_SIGNED, MOST_NEG, '0);
        queue_item(ACT_SIGNED, '0, MOST_NEG);
        for (int i = 0; i < N_RANDOM; i++)
            pending_items.push_back(random_request());
        n_queued = pending_items.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every item taken, every result back, then the pipeline depth.
        while (n_taken < n_queued || expected_quotients.size() > 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
